@@ rtl/vsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// vsfb_pkg
// Shared types and constants for the scaled framebuffer scan-out block.
// ----------------------------------------------------------------------------
package vsfb_pkg;

  // framebuffer geometry defaults
  localparam int FB_WIDTH_DEF  = 80;
  localparam int FB_HEIGHT_DEF = 60;

  // width of a raw row * width + column product
  localparam int PROD_W = 13;

  // raster register reset values
  localparam logic [11:0] H_TOTAL_M1_RST   = 12'd1055;
  localparam logic [11:0] H_SYNC_END_RST   = 12'd128;
  localparam logic [11:0] H_ACT_START_RST  = 12'd216;
  localparam logic [11:0] V_TOTAL_M1_RST   = 12'd627;
  localparam logic [11:0] V_SYNC_END_RST   = 12'd4;
  localparam logic [11:0] V_ACT_START_RST  = 12'd27;
  localparam logic [4:0]  PIX_REPEAT_RST   = 5'd10;
  localparam logic [4:0]  LINE_REPEAT_RST  = 5'd10;

  // repeat limits
  localparam logic [4:0] REPEAT_MIN = 5'd1;
  localparam logic [4:0] REPEAT_MAX = 5'd16;

  // input item kinds
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_H_TOTAL_M1  = 3'd0,
    REG_H_SYNC_END  = 3'd1,
    REG_H_ACT_START = 3'd2,
    REG_V_TOTAL_M1  = 3'd3,
    REG_V_SYNC_END  = 3'd4,
    REG_V_ACT_START = 3'd5,
    REG_PIX_REPEAT  = 3'd6,
    REG_LINE_REPEAT = 3'd7
  } reg_idx_t;

  // raster configuration
  typedef struct packed {
    logic [11:0] h_total_m1;
    logic [11:0] h_sync_end;
    logic [11:0] h_act_start;
    logic [11:0] v_total_m1;
    logic [11:0] v_sync_end;
    logic [11:0] v_act_start;
    logic [4:0]  pix_repeat;
    logic [4:0]  line_repeat;
  } cfg_t;

  // per-clock raster status
  typedef struct packed {
    logic hsync;
    logic vsync;
    logic active;
    logic frame_done;
    logic pix_en;
  } raster_info_t;

  // clamp a repeat count into 1..16
  function automatic logic [4:0] clamp_repeat(input logic [4:0] r);
    logic [4:0] res;
    res = r;
    if (r < REPEAT_MIN) res = REPEAT_MIN;
    if (r > REPEAT_MAX) res = REPEAT_MAX;
    return res;
  endfunction

endpackage

@@ rtl/vsfb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// vsfb_cfg_regs
// Raster configuration registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module vsfb_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output vsfb_pkg::cfg_t    cfg
);

  vsfb_pkg::cfg_t cfg_r;
  vsfb_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (vsfb_pkg::reg_idx_t'(cfg_index))
        vsfb_pkg::REG_H_TOTAL_M1:  cfg_nxt.h_total_m1  = cfg_data;
        vsfb_pkg::REG_H_SYNC_END:  cfg_nxt.h_sync_end  = cfg_data;
        vsfb_pkg::REG_H_ACT_START: cfg_nxt.h_act_start = cfg_data;
        vsfb_pkg::REG_V_TOTAL_M1:  cfg_nxt.v_total_m1  = cfg_data;
        vsfb_pkg::REG_V_SYNC_END:  cfg_nxt.v_sync_end  = cfg_data;
        vsfb_pkg::REG_V_ACT_START: cfg_nxt.v_act_start = cfg_data;
        vsfb_pkg::REG_PIX_REPEAT:  cfg_nxt.pix_repeat  = cfg_data[4:0];
        vsfb_pkg::REG_LINE_REPEAT: cfg_nxt.line_repeat = cfg_data[4:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h_total_m1  <= vsfb_pkg::H_TOTAL_M1_RST;
      cfg_r.h_sync_end  <= vsfb_pkg::H_SYNC_END_RST;
      cfg_r.h_act_start <= vsfb_pkg::H_ACT_START_RST;
      cfg_r.v_total_m1  <= vsfb_pkg::V_TOTAL_M1_RST;
      cfg_r.v_sync_end  <= vsfb_pkg::V_SYNC_END_RST;
      cfg_r.v_act_start <= vsfb_pkg::V_ACT_START_RST;
      cfg_r.pix_repeat  <= vsfb_pkg::PIX_REPEAT_RST;
      cfg_r.line_repeat <= vsfb_pkg::LINE_REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/vsfb_raster.sv @@
// ----------------------------------------------------------------------------
// vsfb_raster
// Horizontal/vertical raster counters and pixel/line replication counters;
// produces sync levels, region flags and the framebuffer read address.
// ----------------------------------------------------------------------------
module vsfb_raster #(
  parameter int FB_WIDTH  = vsfb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = vsfb_pkg::FB_HEIGHT_DEF,
  parameter int AW        = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vsfb_pkg::cfg_t         cfg,
  input  logic                   tick,
  output vsfb_pkg::raster_info_t info,
  output logic [AW-1:0]          rd_addr
);

  localparam int PROD_W_L = vsfb_pkg::PROD_W;

  logic [11:0] h_r, h_nxt;
  logic [11:0] v_r, v_nxt;
  logic [3:0]  sp_r, sp_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [3:0]  sl_r, sl_nxt;
  logic [5:0]  row_r, row_nxt;

  logic [4:0]  pr, lr;
  logic [11:0] h_span, v_span;
  logic [11:0] h_off, v_off;
  logic        hact, vact, act;
  logic [3:0]  sp_eff, sl_eff;
  logic [6:0]  col_eff;
  logic [5:0]  row_eff;
  logic [4:0]  sp_inc, sl_inc;
  logic [PROD_W_L-1:0] addr_full;

  // visible window size in clocks and lines
  assign pr     = vsfb_pkg::clamp_repeat(cfg.pix_repeat);
  assign lr     = vsfb_pkg::clamp_repeat(cfg.line_repeat);
  assign h_span = 12'(FB_WIDTH * pr);
  assign v_span = 12'(FB_HEIGHT * lr);

  // index restarts at the window edges
  always_comb begin
    row_eff = row_r;
    sl_eff  = sl_r;
    col_eff = col_r;
    sp_eff  = sp_r;
    if (h_r == 12'd0 && v_r == cfg.v_act_start) begin
      row_eff = 6'd0;
      sl_eff  = 4'd0;
    end
    if (h_r == cfg.h_act_start) begin
      col_eff = 7'd0;
      sp_eff  = 4'd0;
    end
  end

  // region flags
  assign h_off = h_r - cfg.h_act_start;
  assign v_off = v_r - cfg.v_act_start;
  assign hact  = (h_r >= cfg.h_act_start) && (h_off < h_span);
  assign vact  = (v_r >= cfg.v_act_start) && (v_off < v_span);
  assign act   = hact && vact;

  // status and read address
  assign info.hsync      = h_r < cfg.h_sync_end;
  assign info.vsync      = v_r < cfg.v_sync_end;
  assign info.active     = act;
  assign info.frame_done = (h_r == 12'd0) && (v_r == cfg.v_total_m1);
  assign info.pix_en     = act && ({1'b0, col_eff} < 8'(FB_WIDTH))
                           && ({1'b0, row_eff} < 7'(FB_HEIGHT));
  assign addr_full = PROD_W_L'(row_eff) * PROD_W_L'(FB_WIDTH) + PROD_W_L'(col_eff);
  assign rd_addr   = addr_full[AW-1:0];

  // counter advance for one pixel clock
  assign sp_inc = {1'b0, sp_eff} + 5'd1;
  assign sl_inc = {1'b0, sl_eff} + 5'd1;

  always_comb begin
    sp_nxt  = sp_eff;
    col_nxt = col_eff;
    sl_nxt  = sl_eff;
    row_nxt = row_eff;
    h_nxt   = h_r + 12'd1;
    v_nxt   = v_r;
    if (hact) begin
      if (sp_inc >= pr) begin
        sp_nxt  = 4'd0;
        col_nxt = col_eff + 7'd1;
      end else begin
        sp_nxt = sp_inc[3:0];
      end
    end
    if (h_r >= cfg.h_total_m1) begin
      h_nxt = 12'd0;
      if (vact) begin
        if (sl_inc >= lr) begin
          sl_nxt  = 4'd0;
          row_nxt = row_eff + 6'd1;
        end else begin
          sl_nxt = sl_inc[3:0];
        end
      end
      if (v_r >= cfg.v_total_m1) v_nxt = 12'd0;
      else v_nxt = v_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= '0;
      v_r   <= '0;
      sp_r  <= '0;
      col_r <= '0;
      sl_r  <= '0;
      row_r <= '0;
    end else if (tick) begin
      h_r   <= h_nxt;
      v_r   <= v_nxt;
      sp_r  <= sp_nxt;
      col_r <= col_nxt;
      sl_r  <= sl_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ rtl/vsfb_frame_mem.sv @@
// ----------------------------------------------------------------------------
// vsfb_frame_mem
// Framebuffer memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module vsfb_frame_mem #(
  parameter int FB_WIDTH  = vsfb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = vsfb_pkg::FB_HEIGHT_DEF,
  parameter int AW        = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_req,
  input  logic [5:0]    wr_row,
  input  logic [6:0]    wr_col,
  input  logic [7:0]    wr_value,
  input  logic          rd_req,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          busy
);

  localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int PROD_W = vsfb_pkg::PROD_W;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic              wr_in_range;
  logic [PROD_W-1:0] wr_addr_full;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;

  // write address and range check
  assign wr_in_range  = ({1'b0, wr_row} < 7'(FB_HEIGHT)) && ({1'b0, wr_col} < 8'(FB_WIDTH));
  assign wr_addr_full = PROD_W'(wr_row) * PROD_W'(FB_WIDTH) + PROD_W'(wr_col);

  // clearing sweep takes the port until done
  always_comb begin
    mem_we    = wr_req && wr_in_range;
    mem_waddr = wr_addr_full[AW-1:0];
    mem_wdata = wr_value;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 8'd0;
    end
  end

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) clr_nxt = 1'b0;
      else clr_addr_nxt = clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_req) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_r;

endmodule

@@ rtl/vga_scaled_framebuffer_scanout.sv @@
// ----------------------------------------------------------------------------
// vga_scaled_framebuffer_scanout
// VGA raster scan-out of a small 8-bit framebuffer, scaled by pixel and line
// repetition, with a write path into the framebuffer.
//
//   channel  dir  payload                                      handshake
//   in_      in   tuser: command; tdata: row, col, value        tvalid/tready
//   out_     out  tdata: hsync, vsync, pixel_out, active, f.d.  tvalid/tready
//   cfg_     in   cfg_index, cfg_data                           valid/ready
//
// One input request per cycle when out_tready stays high; a tick's result
// passes through the framebuffer read stage, then the output register.
// After reset the framebuffer is zeroed one entry per cycle, all FB_WIDTH *
// FB_HEIGHT entries (4800 at defaults), with in_tready low; cfg always ready.
// A stalled output holds one result in the output register and one in the
// read stage before in_tready drops.
// ----------------------------------------------------------------------------
module vga_scaled_framebuffer_scanout #(
  parameter int FB_WIDTH  = vsfb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = vsfb_pkg::FB_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // write_row[5:0], write_col[12:6], write_value[20:13]
  input  logic        in_tuser,   // command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // hsync[0], vsync[1], pixel_out[9:2], active[10],
                                  // frame_done[11]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vsfb_pkg::cfg_t         cfg;
  vsfb_pkg::raster_info_t info;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_data;
  logic                   mem_busy;

  logic in_accept, tick, wr_req, advance;

  logic                   s1_v_r, s1_v_nxt;
  vsfb_pkg::raster_info_t s1_info_r;
  logic                   out_v_r, out_v_nxt;
  logic [15:0]            out_data_r;
  logic [7:0]             pix;

  vsfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsfb_raster #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .AW        (AW)
  ) u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .tick    (tick),
    .info    (info),
    .rd_addr (rd_addr)
  );

  vsfb_frame_mem #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (wr_req),
    .wr_row   (in_tdata[5:0]),
    .wr_col   (in_tdata[12:6]),
    .wr_value (in_tdata[20:13]),
    .rd_req   (tick),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (mem_busy)
  );

  // request handshake
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !mem_busy && (advance || !s1_v_r);
  assign in_accept = in_tvalid && in_tready;
  assign tick      = in_accept && (vsfb_pkg::cmd_t'(in_tuser) == vsfb_pkg::CMD_TICK);
  assign wr_req    = in_accept && (vsfb_pkg::cmd_t'(in_tuser) == vsfb_pkg::CMD_WRITE);

  // read stage
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (advance) s1_v_nxt = 1'b0;
    if (tick) s1_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (tick) s1_info_r <= info;
  end

  // output register
  assign pix       = s1_info_r.pix_en ? rd_data : 8'd0;
  assign out_v_nxt = advance ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      out_data_r <= {4'd0, s1_info_r.frame_done, s1_info_r.active, pix,
                     s1_info_r.vsync, s1_info_r.hsync};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // no request taken while the framebuffer is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_tready)
    else $error("request accepted during framebuffer clear");

  // a full read stage that cannot drain blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_accept)
    else $error("request accepted while read stage is stalled");

  // ticks fill the read stage, writes leave it empty
  a_tick_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (s1_v_r == !$past(in_tuser)))
    else $error("read stage occupancy does not follow request kind");

  // a result leaving the read stage lands in the output register
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && advance) |=> out_v_r)
    else $error("result lost between read stage and output");

endmodule

@@ tb/vga_scaled_framebuffer_scanout_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vga_scaled_framebuffer_scanout_tb
// Self-checking bench for the scaled framebuffer scan-out. Tick and write
// requests stream into the block while a shadow raster and framebuffer in the
// bench work out each expected sync/pixel/flag result. Results are compared
// field by field in order. The raster is reprogrammed between phases
// (tiny rasters, repeat scaling and clamping, unreachable windows, register
// extremes, a one-to-one visible window, out-of-step column counters), with
// random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module vga_scaled_framebuffer_scanout_tb;

  localparam int     FB_W          = vsfb_pkg::FB_WIDTH_DEF;
  localparam int     FB_H          = vsfb_pkg::FB_HEIGHT_DEF;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     MAX_PRINTS    = 30;
  localparam longint TIMEOUT_NS    = 1000000;

  typedef struct {
    vsfb_pkg::cmd_t cmd;
    logic [5:0]     row;
    logic [6:0]     col;
    logic [7:0]     value;
  } pixel_req_t;

  typedef struct {
    logic       hsync;
    logic       vsync;
    logic [7:0] pixel;
    logic       active;
    logic       frame_done;
  } scan_out_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // write_row[5:0], write_col[12:6], write_value[20:13]
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // hsync[0], vsync[1], pixel_out[9:2], active[10],
                           // frame_done[11]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  vga_scaled_framebuffer_scanout dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow raster state
  logic [7:0]     fb_shadow [FB_W*FB_H];
  vsfb_pkg::cfg_t raster_cfg;
  logic [11:0]    h_pos, v_pos;
  logic [3:0]     sub_pix, sub_line;
  logic [6:0]     col_idx;
  logic [5:0]     row_idx;
  scan_out_t      pending_scan [$];
  scan_out_t      head_scan;

  // traffic shaping and bookkeeping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int n_errors       = 0;
  int n_checked      = 0;
  int n_sent         = 0;
  int n_ticks        = 0;
  int n_writes       = 0;
  int n_settings     = 0;
  int n_active       = 0;
  int n_frames       = 0;

  function automatic int repeat_count(input logic [4:0] r);
    if (r == 5'd0) return 1;
    if (r > 5'd16) return 16;
    return int'(r);
  endfunction

  function automatic vsfb_pkg::cfg_t raster(input logic [11:0] htm1, hse, has, vtm1, vse,
                                            vas, input logic [4:0] pr, lr);
    vsfb_pkg::cfg_t c;
    c.h_total_m1  = htm1;
    c.h_sync_end  = hse;
    c.h_act_start = has;
    c.v_total_m1  = vtm1;
    c.v_sync_end  = vse;
    c.v_act_start = vas;
    c.pix_repeat  = pr;
    c.line_repeat = lr;
    return c;
  endfunction

  function automatic pixel_req_t req(input vsfb_pkg::cmd_t cmd, input logic [5:0] row,
                                     input logic [6:0] col, input logic [7:0] value);
    pixel_req_t rq;
    rq.cmd   = cmd;
    rq.row   = row;
    rq.col   = col;
    rq.value = value;
    return rq;
  endfunction

  // random request, optionally biased toward the top-left corner of the store
  function automatic pixel_req_t rand_request(input int tick_pct, input bit near_origin);
    pixel_req_t rq;
    rq.cmd = ($urandom_range(99) < tick_pct) ? vsfb_pkg::CMD_TICK : vsfb_pkg::CMD_WRITE;
    if (near_origin && $urandom_range(3) != 0) begin
      rq.row = 6'($urandom_range(7));
      rq.col = 7'($urandom_range(15));
    end else begin
      rq.row = 6'($urandom_range(63));
      rq.col = 7'($urandom_range(127));
    end
    rq.value = 8'($urandom_range(255));
    return rq;
  endfunction

  task automatic reset_raster_shadow();
    foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
    raster_cfg = raster(vsfb_pkg::H_TOTAL_M1_RST, vsfb_pkg::H_SYNC_END_RST,
                        vsfb_pkg::H_ACT_START_RST, vsfb_pkg::V_TOTAL_M1_RST,
                        vsfb_pkg::V_SYNC_END_RST, vsfb_pkg::V_ACT_START_RST,
                        vsfb_pkg::PIX_REPEAT_RST, vsfb_pkg::LINE_REPEAT_RST);
    h_pos    = '0;
    v_pos    = '0;
    sub_pix  = '0;
    col_idx  = '0;
    sub_line = '0;
    row_idx  = '0;
  endtask

  // apply one accepted request to the shadow; a tick queues its scan result
  function automatic void advance_raster(input pixel_req_t rq);
    int        pr, lr, has, vas;
    logic      hact, vact, act;
    scan_out_t r;
    if (rq.cmd == vsfb_pkg::CMD_WRITE) begin
      if (int'(rq.row) < FB_H && int'(rq.col) < FB_W)
        fb_shadow[int'(rq.row) * FB_W + int'(rq.col)] = rq.value;
    end else begin
      pr  = repeat_count(raster_cfg.pix_repeat);
      lr  = repeat_count(raster_cfg.line_repeat);
      has = int'(raster_cfg.h_act_start);
      vas = int'(raster_cfg.v_act_start);

      // window starts restart the scaled indexes
      if (h_pos == 12'd0 && int'(v_pos) == vas) begin
        row_idx  = '0;
        sub_line = '0;
      end
      if (int'(h_pos) == has) begin
        col_idx = '0;
        sub_pix = '0;
      end

      hact = (int'(h_pos) >= has) && (int'(h_pos) - has < FB_W * pr);
      vact = (int'(v_pos) >= vas) && (int'(v_pos) - vas < FB_H * lr);
      act  = hact && vact;

      r.pixel = 8'h00;
      if (act && int'(col_idx) < FB_W && int'(row_idx) < FB_H)
        r.pixel = fb_shadow[int'(row_idx) * FB_W + int'(col_idx)];
      r.hsync      = h_pos < raster_cfg.h_sync_end;
      r.vsync      = v_pos < raster_cfg.v_sync_end;
      r.active     = act;
      r.frame_done = (h_pos == 12'd0) && (v_pos == raster_cfg.v_total_m1);
      pending_scan.push_back(r);

      // horizontal scaling
      if (hact) begin
        if (int'(sub_pix) + 1 >= pr) begin
          sub_pix = '0;
          col_idx = col_idx + 7'd1;
        end else begin
          sub_pix = sub_pix + 4'd1;
        end
      end

      // end of line: vertical scaling and line counter
      if (h_pos >= raster_cfg.h_total_m1) begin
        h_pos = '0;
        if (vact) begin
          if (int'(sub_line) + 1 >= lr) begin
            sub_line = '0;
            row_idx  = row_idx + 6'd1;
          end else begin
            sub_line = sub_line + 4'd1;
          end
        end
        if (v_pos >= raster_cfg.v_total_m1) v_pos = '0;
        else v_pos = v_pos + 12'd1;
      end else begin
        h_pos = h_pos + 12'd1;
      end
    end
  endfunction

  // one request on the input stream, with random idle cycles first
  task automatic send_request(input pixel_req_t rq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = rq.cmd;
    in_tdata  = {3'b000, rq.value, rq.col, rq.row};
    do @(posedge clk); while (in_tready !== 1'b1);
    advance_raster(rq);
    n_sent++;
    if (rq.cmd == vsfb_pkg::CMD_TICK) n_ticks++;
    else n_writes++;
  endtask

  // park the source and let every queued result come out
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_scan.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // program all raster registers while the block is idle
  task automatic set_raster(input vsfb_pkg::cfg_t c);
    vsfb_pkg::reg_idx_t idx;
    logic [11:0]        val;
    wait_all_results();
    for (int i = 0; i < 8; i++) begin
      idx = vsfb_pkg::reg_idx_t'(i);
      case (idx)
        vsfb_pkg::REG_H_TOTAL_M1:  val = c.h_total_m1;
        vsfb_pkg::REG_H_SYNC_END:  val = c.h_sync_end;
        vsfb_pkg::REG_H_ACT_START: val = c.h_act_start;
        vsfb_pkg::REG_V_TOTAL_M1:  val = c.v_total_m1;
        vsfb_pkg::REG_V_SYNC_END:  val = c.v_sync_end;
        vsfb_pkg::REG_V_ACT_START: val = c.v_act_start;
        vsfb_pkg::REG_PIX_REPEAT:  val = {7'd0, c.pix_repeat};
        vsfb_pkg::REG_LINE_REPEAT: val = {7'd0, c.line_repeat};
      endcase
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = idx;
      cfg_data  = val;
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    @(negedge clk);
    cfg_valid  = 1'b0;
    raster_cfg = c;
    n_settings++;
  endtask

  task automatic run_phase(input int n, input int tick_pct, input bit near_origin,
                           input int sidle, input int rstall);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_request(rand_request(tick_pct, near_origin));
  endtask

  // sink side: random stalls plus a counted long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch %s: got %0h want %0h (result %0d)", field, got, want, n_checked);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_scan.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_tdata), 32'd0);
      end else begin
        head_scan = pending_scan.pop_front();
        if (out_tdata[0] !== head_scan.hsync)
          report_mismatch("hsync", 32'(out_tdata[0]), 32'(head_scan.hsync));
        if (out_tdata[1] !== head_scan.vsync)
          report_mismatch("vsync", 32'(out_tdata[1]), 32'(head_scan.vsync));
        if (out_tdata[9:2] !== head_scan.pixel)
          report_mismatch("pixel_out", 32'(out_tdata[9:2]), 32'(head_scan.pixel));
        if (out_tdata[10] !== head_scan.active)
          report_mismatch("active", 32'(out_tdata[10]), 32'(head_scan.active));
        if (out_tdata[11] !== head_scan.frame_done)
          report_mismatch("frame_done", 32'(out_tdata[11]), 32'(head_scan.frame_done));
        n_checked++;
        if (head_scan.active) n_active++;
        if (head_scan.frame_done) n_frames++;
      end
    end
  end

  // corner writes, ignored out-of-range writes, ticks at reset raster
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd0,  7'd0,   8'hFF));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd59, 7'd79,  8'h80));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd0,  7'd79,  8'h01));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd59, 7'd0,   8'h7E));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd60, 7'd0,   8'h55));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd0,  7'd80,  8'hAA));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd63, 7'd127, 8'hFF));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd1,  7'd1,   8'h00));
    send_request(req(vsfb_pkg::CMD_WRITE, 6'd2,  7'd3,   8'hC3));
    repeat (6) send_request(req(vsfb_pkg::CMD_TICK, 6'd0, 7'd0, 8'h00));
    repeat (6) send_request(req(vsfb_pkg::CMD_TICK, 6'd63, 7'd127, 8'hFF));
  endtask

  task automatic test_tiny_raster();
    set_raster(raster(12'd7, 12'd2, 12'd1, 12'd5, 12'd1, 12'd1, 5'd1, 5'd1));
    run_phase(120, 75, 1'b1, 0, 0);
  endtask

  task automatic test_pixel_line_scaling();
    set_raster(raster(12'd23, 12'd3, 12'd2, 12'd11, 12'd2, 12'd1, 5'd3, 5'd2));
    run_phase(120, 80, 1'b1, 59, 0);
  endtask

  // zero repeat acts as one, above sixteen as sixteen
  task automatic test_repeat_clamping();
    set_raster(raster(12'd40, 12'd1, 12'd0, 12'd7, 12'd1, 12'd0, 5'd0, 5'd31));
    run_phase(60, 80, 1'b1, 0, 59);
    set_raster(raster(12'd40, 12'd1, 12'd0, 12'd40, 12'd1, 12'd0, 5'd17, 5'd0));
    run_phase(60, 80, 1'b1, 0, 59);
  endtask

  // active starts past the totals: never visible
  task automatic test_unreachable_window();
    set_raster(raster(12'd10, 12'd20, 12'd50, 12'd8, 12'd20, 12'd30, 5'd4, 5'd4));
    run_phase(60, 80, 1'b1, 9, 9);
  endtask

  task automatic test_register_extremes();
    set_raster(raster(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 5'd1, 5'd1));
    run_phase(30, 70, 1'b1, 0, 0);
    set_raster(raster(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd16, 5'd16));
    run_phase(30, 70, 1'b1, 9, 9);
    set_raster(raster(12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0, 5'd31, 5'd31));
    run_phase(30, 70, 1'b1, 0, 0);
  endtask

  // long sink hold-off fills the pipe, then the source waits for a full drain
  task automatic test_output_backpressure();
    set_raster(raster(12'd31, 12'd4, 12'd3, 12'd15, 12'd2, 12'd2, 5'd2, 5'd3));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    repeat (60) send_request(rand_request(90, 1'b1));
    wait_all_results();
    run_phase(60, 80, 1'b1, 9, 9);
  endtask

  // store mapped one to one with blanking on both axes
  task automatic test_full_frame();
    set_raster(raster(12'd89, 12'd5, 12'd4, 12'd62, 12'd2, 12'd1, 5'd1, 5'd1));
    run_phase(120, 90, 1'b0, 0, 9);
  endtask

  // move the window start behind the counter so the column index runs past
  // the store width while active
  task automatic test_out_of_step_columns();
    set_raster(raster(12'd300, 12'd8, 12'd0, 12'd3, 12'd1, 12'd0, 5'd1, 5'd1));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (h_pos != 12'd150) send_request(req(vsfb_pkg::CMD_TICK, 6'd0, 7'd0, 8'h00));
    for (int c = 0; c < 30; c++) send_request(req(vsfb_pkg::CMD_WRITE, 6'd1, 7'(c), 8'hA5));
    set_raster(raster(12'd300, 12'd8, 12'd100, 12'd3, 12'd1, 12'd0, 5'd1, 5'd1));
    run_phase(80, 100, 1'b0, 0, 0);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = vsfb_pkg::CMD_TICK;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = vsfb_pkg::REG_H_TOTAL_M1;
    cfg_data   = '0;
    reset_raster_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_tiny_raster();
    test_pixel_line_scaling();
    test_repeat_clamping();
    test_unreachable_window();
    test_register_extremes();
    test_output_backpressure();
    test_full_frame();
    test_out_of_step_columns();
    wait_all_results();

    $display("run covered %0d requests (%0d ticks, %0d writes) over %0d raster settings",
             n_sent, n_ticks, n_writes, n_settings);
    $display("checked %0d results: %0d active pixels, %0d frame-done pulses, %0d mismatches",
             n_checked, n_active, n_frames, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("watchdog expired with %0d results outstanding", pending_scan.size());
    $display("tb: failure");
    $finish;
  end

endmodule
